FILE: src/prrd_pkg.sv
// Shared types and constants for the partitioned Rice residual decoder.
`default_nettype none
package prrd_pkg;

  localparam int COUNT_W = 21;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_QLIMIT = 2'd1;
  localparam logic [1:0] ST_TRUNC  = 2'd2;

  localparam logic [1:0] METHOD_WIDE = 2'd1;

  typedef enum logic [7:0] {
    PH_METHOD = 8'b0000_0001,
    PH_ORDER  = 8'b0000_0010,
    PH_PARAM  = 8'b0000_0100,
    PH_RAWLEN = 8'b0000_1000,
    PH_UNARY  = 8'b0001_0000,
    PH_REM    = 8'b0010_0000,
    PH_RAW    = 8'b0100_0000,
    PH_DONE   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic signed [31:0]   residual;
    logic [COUNT_W-1:0]   repeat_count;
    logic                 block_done;
    logic [1:0]           status;
  } result_t;

  // Terms for the count of samples still owed when the stream ends early:
  // left = add_v + mul_a * mul_b.
  typedef struct packed {
    logic                 blk_done;
    logic [15:0]          mul_a;
    logic [COUNT_W-1:0]   mul_b;
    logic [COUNT_W-1:0]   add_v;
  } trunc_t;

endpackage
`default_nettype wire

FILE: src/prrd_if.sv
// Valid/ready channel interfaces for the byte input and the result output.
`default_nettype none
interface prrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;
  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface prrd_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [31:0]               residual;
  logic [prrd_pkg::COUNT_W-1:0]     repeat_count;
  logic                             block_done;
  logic [1:0]                       status;
  modport source (output valid, output residual, output repeat_count,
                  output block_done, output status, input ready);
  modport sink (input valid, input residual, input repeat_count,
                input block_done, input status, output ready);
endinterface
`default_nettype wire

FILE: src/prrd_bit_dec.sv
// Bit-level decode state machine: consumes one stream bit per advance.
`default_nettype none
module prrd_bit_dec #(
  parameter int QUOTIENT_LIMIT = 65535
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          advance,
  input  wire logic                          bit_in,
  input  wire logic                          clear,
  input  wire logic [prrd_pkg::COUNT_W-1:0]  sample_count,
  output logic                               emit_v,
  output prrd_pkg::result_t                  emit_d,
  output prrd_pkg::trunc_t                   trunc
);
  import prrd_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic               wide_r, wide_nxt;
  logic [3:0]         order_r, order_nxt;
  logic [15:0]        parts_r, parts_nxt;
  logic [COUNT_W-1:0] samples_r, samples_nxt;
  logic [4:0]         param_r, param_nxt;
  logic [4:0]         raww_r, raww_nxt;
  logic [15:0]        quot_r, quot_nxt;
  logic [31:0]        acc_r, acc_nxt;
  logic [5:0]         need_r, need_nxt;

  logic [COUNT_W-1:0] size;
  logic [31:0]        acc_sh, val, raw_mask;
  logic [5:0]         need_dec;
  logic [15:0]        q_inc, p_dec;
  logic [COUNT_W-1:0] s_dec;
  logic               do_fin, do_endp, do_start, start_raw, marker;
  logic [4:0]         start_rw;
  logic [5:0]         param_need;

  assign size       = sample_count >> order_r;
  assign acc_sh     = {acc_r[30:0], bit_in};
  assign need_dec   = need_r - 6'd1;
  assign q_inc      = quot_r + 16'd1;
  assign p_dec      = parts_r - 16'd1;
  assign s_dec      = samples_r - COUNT_W'(1);
  assign val        = ({16'b0, quot_r} << param_r) | acc_sh;
  assign raw_mask   = (32'h1 << raww_r) - 32'd1;
  assign param_need = wide_r ? 6'd5 : 6'd4;

  always_comb begin
    phase_nxt = phase_r; wide_nxt = wide_r; order_nxt = order_r;
    parts_nxt = parts_r; samples_nxt = samples_r; param_nxt = param_r;
    raww_nxt = raww_r; quot_nxt = quot_r; acc_nxt = acc_r; need_nxt = need_r;
    emit_v = 1'b0;
    emit_d = '0;
    do_fin = 1'b0; do_endp = 1'b0; do_start = 1'b0; start_raw = 1'b0;
    marker = 1'b0; start_rw = '0;

    unique case (phase_r)
      PH_DONE: ;
      PH_UNARY: begin
        if (!bit_in) begin
          quot_nxt = q_inc;
          if (q_inc >= 16'(QUOTIENT_LIMIT)) begin
            emit_v = 1'b1;
            emit_d.repeat_count = COUNT_W'(1);
            emit_d.status = ST_QLIMIT;
            do_fin = 1'b1;
          end
        end else if (param_r == 5'd0) begin
          emit_v = 1'b1;
          emit_d.residual = {17'b0, quot_r[15:1]} ^ {32{quot_r[0]}};
          emit_d.repeat_count = COUNT_W'(1);
          do_fin = 1'b1;
        end else begin
          phase_nxt = PH_REM;
          need_nxt = {1'b0, param_r};
          acc_nxt = '0;
        end
      end
      default: begin
        acc_nxt = acc_sh;
        need_nxt = need_dec;
        if (need_dec == 6'd0) begin
          unique case (phase_r)
            PH_METHOD: begin
              wide_nxt = (acc_sh[1:0] == METHOD_WIDE);
              phase_nxt = PH_ORDER;
              need_nxt = 6'd4;
              acc_nxt = '0;
            end
            PH_ORDER: begin
              order_nxt = acc_sh[3:0];
              parts_nxt = 16'h1 << acc_sh[3:0];
              phase_nxt = PH_PARAM;
              need_nxt = param_need;
              acc_nxt = '0;
            end
            PH_PARAM: begin
              param_nxt = acc_sh[4:0];
              if (acc_sh[4:0] < (wide_r ? 5'd31 : 5'd15)) begin
                do_start = 1'b1;
              end else begin
                phase_nxt = PH_RAWLEN;
                need_nxt = 6'd5;
                acc_nxt = '0;
              end
            end
            PH_RAWLEN: begin
              raww_nxt = acc_sh[4:0];
              do_start = 1'b1;
              start_raw = 1'b1;
              start_rw = acc_sh[4:0];
            end
            PH_REM: begin
              emit_v = 1'b1;
              emit_d.residual = {1'b0, val[31:1]} ^ {32{val[0]}};
              emit_d.repeat_count = COUNT_W'(1);
              do_fin = 1'b1;
            end
            PH_RAW: begin
              emit_v = 1'b1;
              emit_d.residual = acc_sh[raww_r - 5'd1] ? (acc_sh | ~raw_mask) : acc_sh;
              emit_d.repeat_count = COUNT_W'(1);
              do_fin = 1'b1;
            end
            default: ;
          endcase
        end
      end
    endcase

    if (do_start) begin
      acc_nxt = '0;
      quot_nxt = '0;
      if (size == '0) begin
        do_endp = 1'b1;
        marker = 1'b1;
      end else begin
        samples_nxt = size;
        if (start_raw) begin
          phase_nxt = PH_RAW;
          need_nxt = {1'b0, start_rw};
          if (start_rw == 5'd0) begin
            // zero-width raw partition: one run result covers it
            emit_v = 1'b1;
            emit_d.repeat_count = size;
            samples_nxt = '0;
            do_endp = 1'b1;
          end
        end else begin
          phase_nxt = PH_UNARY;
        end
      end
    end

    if (do_fin) begin
      quot_nxt = '0;
      acc_nxt = '0;
      samples_nxt = s_dec;
      if (s_dec == '0) begin
        do_endp = 1'b1;
      end else if (phase_r == PH_REM) begin
        phase_nxt = PH_UNARY;
      end else if (phase_r == PH_RAW) begin
        need_nxt = {1'b0, raww_r};
      end
    end

    if (do_endp) begin
      parts_nxt = p_dec;
      acc_nxt = '0;
      if (p_dec == 16'd0) begin
        phase_nxt = PH_DONE;
        if (marker) begin
          emit_v = 1'b1;
          emit_d = '0;
        end
        emit_d.block_done = 1'b1;
      end else begin
        phase_nxt = PH_PARAM;
        need_nxt = param_need;
      end
    end
  end

  // samples still owed if the stream stops here
  always_comb begin
    trunc.blk_done = (phase_r == PH_DONE);
    trunc.mul_b = size;
    if (phase_r == PH_METHOD || phase_r == PH_ORDER) begin
      trunc.mul_a = '0;
      trunc.add_v = sample_count;
    end else if (phase_r == PH_PARAM || phase_r == PH_RAWLEN) begin
      trunc.mul_a = parts_r;
      trunc.add_v = '0;
    end else begin
      trunc.mul_a = p_dec;
      trunc.add_v = samples_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      phase_r <= PH_METHOD;
      wide_r <= 1'b0;
      order_r <= '0;
      parts_r <= '0;
      samples_r <= '0;
      param_r <= '0;
      raww_r <= '0;
      quot_r <= '0;
      acc_r <= '0;
      need_r <= 6'd2;
    end else if (advance) begin
      phase_r <= phase_nxt;
      wide_r <= wide_nxt;
      order_r <= order_nxt;
      parts_r <= parts_nxt;
      samples_r <= samples_nxt;
      param_r <= param_nxt;
      raww_r <= raww_nxt;
      quot_r <= quot_nxt;
      acc_r <= acc_nxt;
      need_r <= need_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/prrd_out_reg.sv
// Output register holding one result beat until the sink takes it.
`default_nettype none
module prrd_out_reg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         load,
  input  prrd_pkg::result_t load_d,
  output logic              free,
  prrd_out_if.source        out_ch
);
  import prrd_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      data_r <= load_d;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.residual     = data_r.residual;
  assign out_ch.repeat_count = data_r.repeat_count;
  assign out_ch.block_done   = data_r.block_done;
  assign out_ch.status       = data_r.status;

endmodule
`default_nettype wire

FILE: src/partitioned_rice_residual_decoder.sv
// Top level: byte sequencer around the serial Rice decode unit.
`default_nettype none
// Partitioned Rice residual decoder. Takes the coded stream one byte per
// input beat, MSB first, and produces one result beat per decoded residual
// (or per zero run, quotient-limit sample, empty-block marker or truncation
// record). Each byte is shifted through a single bit-serial decode unit, one
// bit per clock while the shifter is not stalled. A byte is accepted in
// idle and then shifted; no new byte is taken before its last bit is
// shifted. Any cycle in which a result is due while the output register is
// still full stalls the bit shifter for that cycle. After a beat marked
// final_byte, S_TMUL forms the owed sample count on a 16x21 multiplier and
// S_TEMIT posts the truncation record, unless the block was already done,
// while the decoder is returned to its reset state (sample_count kept).
// S_TEMIT is held while that record is due and the output register is full.
// in_ch.ready is high only while the block waits for a byte. sample_count
// is written through cfg_we/cfg_wdata and is read when a partition starts.
module partitioned_rice_residual_decoder #(
  parameter int QUOTIENT_LIMIT = 65535
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  prrd_in_if.sink                            in_ch,
  prrd_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [prrd_pkg::COUNT_W-1:0]  cfg_wdata
);
  import prrd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_BITS  = 4'b0010,
    S_TMUL  = 4'b0100,
    S_TEMIT = 4'b1000
  } seq_t;

  seq_t               state_r, state_nxt;
  logic [COUNT_W-1:0] count_r;
  logic [7:0]         byte_r;
  logic               final_r;
  logic [2:0]         bit_idx_r;
  logic [COUNT_W-1:0] left_r;
  logic               skip_r;

  logic               emit_v, free, advance, clear, load;
  result_t            emit_d, load_d;
  trunc_t             trunc;
  logic [36:0]        prod;

  // sample count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_W'(4096);
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);

  // one bit per cycle; hold while a result is due and the output is full
  assign advance = (state_r == S_BITS) && (!emit_v || free);
  assign clear   = (state_r == S_TEMIT) && (skip_r || free);

  prrd_bit_dec #(.QUOTIENT_LIMIT(QUOTIENT_LIMIT)) u_dec (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .bit_in       (byte_r[7]),
    .clear        (clear),
    .sample_count (count_r),
    .emit_v       (emit_v),
    .emit_d       (emit_d),
    .trunc        (trunc)
  );

  assign prod = {21'b0, trunc.mul_a} * {16'b0, trunc.mul_b};

  always_comb begin
    load = 1'b0;
    load_d = emit_d;
    if (state_r == S_BITS) begin
      load = emit_v;
    end else if (state_r == S_TEMIT) begin
      load = !skip_r;
      load_d.residual = '0;
      load_d.repeat_count = left_r;
      load_d.block_done = 1'b1;
      load_d.status = ST_TRUNC;
    end
  end

  prrd_out_reg u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load),
    .load_d (load_d),
    .free   (free),
    .out_ch (out_ch)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_BITS;
      end
      S_BITS: begin
        if (advance && bit_idx_r == 3'd7) begin
          state_nxt = final_r ? S_TMUL : S_IDLE;
        end
      end
      S_TMUL: state_nxt = S_TEMIT;
      S_TEMIT: begin
        if (clear) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bit_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE) begin
        bit_idx_r <= '0;
      end else if (advance) begin
        bit_idx_r <= bit_idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      byte_r <= in_ch.data_byte;
      final_r <= in_ch.final_byte;
    end else if (advance) begin
      byte_r <= {byte_r[6:0], 1'b0};
    end
    if (state_r == S_TMUL) begin
      left_r <= prod[COUNT_W-1:0] + trunc.add_v;
      skip_r <= trunc.blk_done;
    end
  end

endmodule
`default_nettype wire
